FILE: sv/buzzer_sample_generator_top_defines.svh
`ifndef BUZZER_SAMPLE_GENERATOR_TOP_DEFINES_SVH
`define BUZZER_SAMPLE_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication
`define BSG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BSG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/bsg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bsg_pkg;

    localparam int PERIOD_W   = 25;
    localparam int VOL_W      = 7;
    localparam int LEN_W      = 13;
    localparam int WORD_W     = 16;
    localparam int DUR_W      = 16;
    localparam int ACC_W      = 26;
    localparam int POS_W      = 12;
    localparam int SAMPLE_W   = 15;
    localparam int AMP_W      = 14;
    localparam int CNT_W      = 6;
    localparam int EDGE_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;
    localparam int RECIP_W    = 19;
    localparam int AMP_SHIFT  = 23;
    localparam int PROD_W     = 37;

    localparam logic [PERIOD_W-1:0] PERIOD_MIN_Q8  = 25'd262144;
    localparam logic [PERIOD_W-1:0] PERIOD_RST     = 25'd5333333;
    localparam logic [VOL_W-1:0]    VOL_MAX        = 7'd100;
    localparam logic [LEN_W-1:0]    LEN_RST        = 13'd1024;
    localparam logic [LEN_W-1:0]    MAX_BUFFER_LEN = 13'd4096;
    localparam logic [AMP_W-1:0]    AMP_RST        = 14'd8192;
    // ceil(2^23 / 25): amp = vol * 2048 / 25
    localparam logic [RECIP_W-1:0]  AMP_RECIP      = 19'd335545;
    localparam logic [CNT_W-1:0]    CNT_LAST       = 6'd63;
    localparam logic [EDGE_W-1:0]   EDGE_LAST      = 4'd15;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUF_LEN = 2'd2;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    typedef struct packed {
        logic load;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic due;
        logic more;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

FILE: sv/bsg_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
interface bsg_in_if;
    logic                        valid;
    logic                        ready;
    logic [bsg_pkg::WORD_W-1:0]  irq_word;
    logic [bsg_pkg::DUR_W-1:0]   instr_time_ns;

    modport source (output valid, output irq_word, output instr_time_ns, input ready);
    modport sink   (input valid, input irq_word, input instr_time_ns, output ready);
endinterface

interface bsg_out_if;
    logic             valid;
    logic             ready;
    bsg_pkg::t_sample sample_value;
    logic             run_last;
    logic             buffer_full;

    modport source (output valid, output sample_value, output run_last, output buffer_full,
                    input ready);
    modport sink   (input valid, input sample_value, input run_last, input buffer_full,
                    output ready);
endinterface

interface bsg_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bsg_pkg::CFG_IDX_W-1:0]  index;
    logic [bsg_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/bsg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module bsg_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    input  bsg_pkg::t_sts  i_sts,
    output logic           o_in_ready,
    output bsg_pkg::t_cmd  o_cmd
);
    import bsg_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (!i_sts.due) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free && !i_sts.more) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_RUN: begin
                o_cmd.emit = i_sts.due && i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
                o_cmd      = '0;
            end
        endcase
    end
endmodule
`default_nettype wire

FILE: sv/bsg_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module bsg_dpath (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  bsg_pkg::t_cmd                    i_cmd,
    output bsg_pkg::t_sts                    o_sts,
    input  wire                              i_cfg_we,
    input  wire  [bsg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [bsg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire  [bsg_pkg::WORD_W-1:0]       i_irq_word,
    input  wire  [bsg_pkg::DUR_W-1:0]        i_instr_time_ns,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output bsg_pkg::t_sample                 o_sample_value,
    output logic                             o_run_last,
    output logic                             o_buffer_full
);
    import bsg_pkg::*;

    logic [PERIOD_W-1:0] r_period;
    logic [AMP_W-1:0]    r_amp;
    logic [LEN_W-1:0]    r_len;
    logic                r_prev_bit;
    logic [EDGE_W-1:0]   r_edge_cnt;
    logic                r_neg;
    logic [ACC_W-1:0]    r_accum;
    logic [POS_W-1:0]    r_pos;
    logic [CNT_W-1:0]    r_count;
    logic                r_out_valid;
    t_sample             r_sample;
    logic                r_run_last;
    logic                r_full;

    logic [VOL_W-1:0]    w_vol;
    logic [PROD_W-1:0]   w_amp_prod;
    logic [PERIOD_W-1:0] w_period;
    logic [LEN_W-1:0]    w_len;
    logic [LEN_W-1:0]    w_pos_inc;
    logic                w_full;
    t_sample             w_mag;

    // volume clamp and amplitude on the write
    assign w_vol      = (i_cfg_data[VOL_W-1:0] > VOL_MAX) ? VOL_MAX : i_cfg_data[VOL_W-1:0];
    assign w_amp_prod = PROD_W'({w_vol, 11'b0}) * PROD_W'(AMP_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RST;
            r_amp    <= AMP_RST;
            r_len    <= LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PERIOD:  r_period <= i_cfg_data[PERIOD_W-1:0];
                CFG_VOLUME:  r_amp    <= w_amp_prod[AMP_SHIFT +: AMP_W];
                CFG_BUF_LEN: r_len    <= i_cfg_data[LEN_W-1:0];
                default:     ;
            endcase
        end
    end

    assign w_period = (r_period < PERIOD_MIN_Q8) ? PERIOD_MIN_Q8 : r_period;

    always_comb begin
        w_len = r_len;
        if (r_len == '0) begin
            w_len = LEN_W'(1);
        end else if (r_len > MAX_BUFFER_LEN) begin
            w_len = MAX_BUFFER_LEN;
        end
    end

    assign w_pos_inc = {1'b0, r_pos} + LEN_W'(1);
    assign w_full    = (w_pos_inc >= w_len);
    assign w_mag     = t_sample'({1'b0, r_amp});

    assign o_sts.due      = (r_accum > {1'b0, w_period});
    assign o_sts.more     = (r_accum > {w_period, 1'b0}) && (r_count != CNT_LAST);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_bit  <= 1'b0;
            r_edge_cnt  <= '0;
            r_neg       <= 1'b0;
            r_accum     <= '0;
            r_pos       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_prev_bit <= i_irq_word[WORD_W-1];
                if (i_irq_word[WORD_W-1] != r_prev_bit) begin
                    if (r_edge_cnt == EDGE_LAST) begin
                        r_edge_cnt <= '0;
                        r_neg      <= !r_neg;
                    end else begin
                        r_edge_cnt <= r_edge_cnt + EDGE_W'(1);
                    end
                end
                r_accum <= r_accum + {2'b0, i_instr_time_ns, 8'b0};
                r_count <= '0;
            end
            if (i_cmd.emit) begin
                r_accum <= r_accum - {1'b0, w_period};
                r_pos   <= w_full ? '0 : w_pos_inc[POS_W-1:0];
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_sample   <= r_neg ? -w_mag : w_mag;
            r_run_last <= !o_sts.more;
            r_full     <= w_full;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample_value = r_sample;
    assign o_run_last     = r_run_last;
    assign o_buffer_full  = r_full;
endmodule
`default_nettype wire

FILE: sv/buzzer_sample_generator_top.sv
// Flow: an input word is taken in S_IDLE; the controller then enters S_RUN and, while
//   samples are due, emits up to 64 sample words per input, one sample a cycle while the
//   output register is free, each held in the output register; no input is taken in S_RUN.
// Reset: i_rst_n synchronous, active low; clears all state but the output data registers,
//   restores the register reset values; no clearing pass, ready the cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "buzzer_sample_generator_top_defines.svh"
module buzzer_sample_generator_top (
    input  wire        i_clk,
    input  wire        i_rst_n,
    bsg_in_if.sink     i_in,
    bsg_out_if.source  o_out,
    bsg_cfg_if.sink    i_cfg
);
    import bsg_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    bsg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    bsg_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .i_irq_word      (i_in.irq_word),
        .i_instr_time_ns (i_in.instr_time_ns),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_sample_value  (o_out.sample_value),
        .o_run_last      (o_out.run_last),
        .o_buffer_full   (o_out.buffer_full)
    );

    `BSG_ASSERT_NXT(a_emit_valid, i_clk, i_rst_n, w_cmd.emit, o_out.valid,
        "emitted sample word not held in output register")
    `BSG_ASSERT_IMP(a_no_accept_on_emit, i_clk, i_rst_n, i_in.valid && i_in.ready,
        !w_cmd.emit, "input word taken while a sample is emitted")
    `BSG_ASSERT_NXT(a_last_to_idle, i_clk, i_rst_n, w_cmd.emit && !w_sts.more, i_in.ready,
        "controller did not return to idle after last sample word")
    `BSG_ASSERT_IMP(a_sample_range, i_clk, i_rst_n, o_out.valid,
        (o_out.sample_value <= 15'sd8192) && (o_out.sample_value >= -15'sd8192),
        "sample word out of range")
endmodule
`default_nettype wire
